>>> design/pcc_pkg.sv
// Shared constants, types and the area saturation helper of the polygon cell checker.
`default_nettype none

package pcc_pkg;

   localparam int MAX_DEGREE  = 16;
   localparam int COORD_BITS  = 24;
   localparam int ID_BITS     = 20;
   localparam int NODE_BITS   = ID_BITS + 1;
   localparam int AREA_BITS   = 52;
   localparam int DEG_BITS    = $clog2(MAX_DEGREE + 2);
   localparam int PROD_BITS   = 2 * COORD_BITS;
   localparam int TERM_BITS   = PROD_BITS + 1;
   localparam int WIDE_BITS   = ((AREA_BITS > TERM_BITS) ? AREA_BITS : TERM_BITS) + 1;
   localparam int DEFECT_BITS = 3;

   localparam logic [DEFECT_BITS-1:0] DEFECT_NONE   = 3'd0;
   localparam logic [DEFECT_BITS-1:0] DEFECT_DEGREE = 3'd1;
   localparam logic [DEFECT_BITS-1:0] DEFECT_ID     = 3'd2;
   localparam logic [DEFECT_BITS-1:0] DEFECT_REPEAT = 3'd3;
   localparam logic [DEFECT_BITS-1:0] DEFECT_RADIUS = 3'd4;
   localparam logic [DEFECT_BITS-1:0] DEFECT_AREA   = 3'd5;

   localparam logic [DEG_BITS-1:0] MIN_DEG_VALUE = DEG_BITS'(3);
   localparam logic [DEG_BITS-1:0] MAX_DEG_VALUE = DEG_BITS'(MAX_DEGREE);
   localparam logic [DEG_BITS-1:0] DEG_SAT_VALUE = DEG_BITS'(MAX_DEGREE + 1);

   localparam logic [NODE_BITS-1:0] NODE_COUNT_RESET = NODE_BITS'(1) << ID_BITS;

   typedef logic        [ID_BITS-1:0]    id_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [TERM_BITS-1:0]  term_type;
   typedef logic signed [AREA_BITS-1:0]  area_type;
   typedef logic        [DEG_BITS-1:0]   degree_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } chain_ctl_type;

   typedef struct packed {
      logic radius;
      logic dup;
      logic id_range;
   } flags_type;

   // Clamp a widened sum into the signed area range.
   function automatic area_type sat_area(input logic signed [WIDE_BITS-1:0] value);
      logic signed [WIDE_BITS-1:0] hi;
      logic signed [WIDE_BITS-1:0] lo;
      area_type                    result;
      hi = {{(WIDE_BITS - AREA_BITS + 1){1'b0}}, {(AREA_BITS - 1){1'b1}}};
      lo = ~hi;
      if (value > hi) begin
         result = hi[AREA_BITS-1:0];
      end else if (value < lo) begin
         result = lo[AREA_BITS-1:0];
      end else begin
         result = value[AREA_BITS-1:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

>>> design/pcc_id_cell.sv
// One cell of the vertex id chain: holds one stored id and compares it with the probe.
`default_nettype none

module pcc_id_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  pcc_pkg::chain_ctl_type ctl,
   input  pcc_pkg::id_type       nb_id,
   input  logic                  nb_valid,
   input  pcc_pkg::id_type       probe_id,
   output pcc_pkg::id_type       id_out,
   output logic                  valid_out,
   output logic                  match
);
   import pcc_pkg::*;

   id_type id_ff;
   logic   valid_ff;
   logic   valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift) begin
         valid_in = nb_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         id_ff <= nb_id;
      end
   end

   assign id_out    = id_ff;
   assign valid_out = valid_ff;
   assign match     = valid_ff && (id_ff == probe_id);

endmodule

`default_nettype wire

>>> design/pcc_id_chain.sv
// Row of id cells that remembers the first vertex ids of a cell and flags a repeat.
`default_nettype none

module pcc_id_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  pcc_pkg::chain_ctl_type ctl,
   input  pcc_pkg::id_type        probe_id,
   output logic                   dup_hit
);
   import pcc_pkg::*;

   id_type                  link_id    [MAX_DEGREE];
   logic   [MAX_DEGREE-1:0] link_valid;
   logic   [MAX_DEGREE-1:0] hit;

   for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_cell
      if (k == 0) begin : g_head
         pcc_id_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .nb_id     (probe_id),
            .nb_valid  (1'b1),
            .probe_id  (probe_id),
            .id_out    (link_id[k]),
            .valid_out (link_valid[k]),
            .match     (hit[k])
         );
      end else begin : g_body
         pcc_id_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .nb_id     (link_id[k-1]),
            .nb_valid  (link_valid[k-1]),
            .probe_id  (probe_id),
            .id_out    (link_id[k]),
            .valid_out (link_valid[k]),
            .match     (hit[k])
         );
      end
   end

   assign dup_hit = |hit;

endmodule

`default_nettype wire

>>> design/polygon_cell_checker.sv
// Top level of the polygon cell checker: vertex intake, shoelace pipeline and result register.
`default_nettype none

// The block takes one polygon vertex per request and, on the vertex that carries
// cell_end, returns one result with twice the signed shoelace area (Q28.24,
// saturating), the vertex count (saturating at MAX_DEGREE + 1) and the first
// defect found: degree, node id range, repeated vertex, negative radius, then
// non-positive area. A vertex is taken in every cycle while the pipeline moves;
// the throughput of one vertex per clock is set by the area accumulator, which
// does a single saturating add per vertex. A closing vertex passes through stages
// 1, 2 and 3 into the output register, whose result is held on the rsp ports
// while rsp_stall is high. While a result waits, the next closing vertex stays
// in stage 3, and the intake stalls once the stages behind it are full. Ids are
// checked against a row of MAX_DEGREE id cells that shift in the first ids of a
// cell and compare all of them with the incoming id in the same cycle. There is
// no clearing pass after reset. The node count register may only be written
// while no cell is in progress and no result is pending; the write port is
// always ready.

module polygon_cell_checker (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  pcc_pkg::id_type                   req_vertex_id,
   input  pcc_pkg::coord_type                req_coord_r,
   input  pcc_pkg::coord_type                req_coord_z,
   input  logic                              req_cell_end,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pcc_pkg::DEFECT_BITS-1:0]   rsp_defect,
   output pcc_pkg::area_type                 rsp_double_area,
   output pcc_pkg::degree_type               rsp_degree,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcc_pkg::NODE_BITS-1:0]     csr_wdata
);
   import pcc_pkg::*;

   // Configuration.
   logic [NODE_BITS-1:0] node_count_ff;

   // Per-cell running state, updated as each vertex is taken (the area as it leaves stage 2).
   degree_type count_ff, count_in;
   flags_type  flags_ff, flags_in;
   coord_type  first_r_ff, first_z_ff, prev_r_ff, prev_z_ff;
   area_type   area_ff, area_in;

   // Stage 1: products.
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_last_ff, s1_first_ff;
   prod_type   s1_p0_ff, s1_p1_ff, s1_p2_ff, s1_p3_ff;
   flags_type  s1_flags_ff;
   degree_type s1_degree_ff;

   // Stage 2: edge terms.
   logic       s2_valid_ff, s2_valid_in;
   logic       s2_last_ff;
   term_type   s2_t1_ff, s2_t2_ff;
   flags_type  s2_flags_ff;
   degree_type s2_degree_ff;

   // Stage 3: running sum including this vertex, closing term pending.
   logic       s3_valid_ff, s3_valid_in;
   logic       s3_last_ff;
   area_type   s3_sum_ff;
   term_type   s3_t2_ff;
   flags_type  s3_flags_ff;
   degree_type s3_degree_ff;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DEFECT_BITS-1:0] rsp_defect_ff, defect_calc;
   area_type               rsp_area_ff, total_area;
   degree_type             rsp_degree_ff;

   logic          req_accept;
   logic          out_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free;
   logic          is_first;
   degree_type    degree_now;
   flags_type     flags_now;
   logic          dup_hit;
   chain_ctl_type chain_ctl;
   area_type      sum_now;

   // ------------------------------------------------------------------
   // Flow control. Each stage moves when its successor has room; vertices
   // that do not close a cell drop out after stage 3.
   // ------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s3_go      = s3_valid_ff && (!s3_last_ff || out_free);
   assign s3_free    = !s3_valid_ff || s3_go;
   assign s2_go      = s2_valid_ff && s3_free;
   assign s2_free    = !s2_valid_ff || s2_go;
   assign s1_go      = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s1_go;
   assign req_stall  = !s1_free;
   assign req_accept = req_valid && s1_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         node_count_ff <= csr_wdata;
      end
   end

   // ------------------------------------------------------------------
   // Vertex intake: checks, id chain control and cell bookkeeping.
   // ------------------------------------------------------------------
   assign is_first   = (count_ff == '0);
   assign degree_now = (count_ff < DEG_SAT_VALUE) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      flags_now.id_range = flags_ff.id_range || ({1'b0, req_vertex_id} >= node_count_ff);
      flags_now.dup      = flags_ff.dup || dup_hit;
      flags_now.radius   = flags_ff.radius || req_coord_r[COORD_BITS-1];
   end

   // Only the first MAX_DEGREE ids of a cell are kept; a closing vertex
   // empties the row instead of being stored.
   assign chain_ctl.shift = req_accept && !req_cell_end && (count_ff < MAX_DEG_VALUE);
   assign chain_ctl.clear = req_accept && req_cell_end;

   pcc_id_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .ctl      (chain_ctl),
      .probe_id (req_vertex_id),
      .dup_hit  (dup_hit)
   );

   always_comb begin
      count_in = count_ff;
      flags_in = flags_ff;
      if (req_accept) begin
         count_in = req_cell_end ? '0 : degree_now;
         flags_in = req_cell_end ? '0 : flags_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         flags_ff <= '0;
      end else begin
         count_ff <= count_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         prev_r_ff <= req_coord_r;
         prev_z_ff <= req_coord_z;
         if (is_first) begin
            first_r_ff <= req_coord_r;
            first_z_ff <= req_coord_z;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: the four cross products of the edge into this vertex and of
   // the closing edge back to the first vertex.
   // ------------------------------------------------------------------
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_last_ff   <= req_cell_end;
         s1_first_ff  <= is_first;
         s1_flags_ff  <= flags_now;
         s1_degree_ff <= degree_now;
         s1_p0_ff     <= PROD_BITS'(prev_r_ff) * PROD_BITS'(req_coord_z);
         s1_p1_ff     <= PROD_BITS'(req_coord_r) * PROD_BITS'(prev_z_ff);
         s1_p2_ff     <= PROD_BITS'(req_coord_r) * PROD_BITS'(first_z_ff);
         s1_p3_ff     <= PROD_BITS'(first_r_ff) * PROD_BITS'(req_coord_z);
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: edge terms. A first vertex has no incoming edge, and a cell
   // of one vertex closes on itself, so both terms are zero there.
   // ------------------------------------------------------------------
   assign s2_valid_in = s1_go || (s2_valid_ff && !s2_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_last_ff   <= s1_last_ff;
         s2_flags_ff  <= s1_flags_ff;
         s2_degree_ff <= s1_degree_ff;
         if (s1_first_ff) begin
            s2_t1_ff <= '0;
            s2_t2_ff <= '0;
         end else begin
            s2_t1_ff <= TERM_BITS'(s1_p0_ff) - TERM_BITS'(s1_p1_ff);
            s2_t2_ff <= TERM_BITS'(s1_p2_ff) - TERM_BITS'(s1_p3_ff);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: the running shoelace sum. It is updated once per vertex as the
   // vertex leaves stage 2, and it restarts from zero after a closing vertex.
   // ------------------------------------------------------------------
   assign sum_now     = sat_area(WIDE_BITS'(area_ff) + WIDE_BITS'(s2_t1_ff));
   assign s3_valid_in = s2_go || (s3_valid_ff && !s3_go);

   always_comb begin
      area_in = area_ff;
      if (s2_go) begin
         area_in = s2_last_ff ? '0 : sum_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         area_ff     <= '0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         area_ff     <= area_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         s3_last_ff   <= s2_last_ff;
         s3_sum_ff    <= sum_now;
         s3_t2_ff     <= s2_t2_ff;
         s3_flags_ff  <= s2_flags_ff;
         s3_degree_ff <= s2_degree_ff;
      end
   end

   // ------------------------------------------------------------------
   // Closing edge and defect ranking into the output register.
   // ------------------------------------------------------------------
   assign total_area = sat_area(WIDE_BITS'(s3_sum_ff) + WIDE_BITS'(s3_t2_ff));

   always_comb begin
      if ((s3_degree_ff < MIN_DEG_VALUE) || (s3_degree_ff > MAX_DEG_VALUE)) begin
         defect_calc = DEFECT_DEGREE;
      end else if (s3_flags_ff.id_range) begin
         defect_calc = DEFECT_ID;
      end else if (s3_flags_ff.dup) begin
         defect_calc = DEFECT_REPEAT;
      end else if (s3_flags_ff.radius) begin
         defect_calc = DEFECT_RADIUS;
      end else if (total_area[AREA_BITS-1] || (total_area == '0)) begin
         defect_calc = DEFECT_AREA;
      end else begin
         defect_calc = DEFECT_NONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s3_go && s3_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_go && s3_last_ff) begin
         rsp_defect_ff <= defect_calc;
         rsp_area_ff   <= total_area;
         rsp_degree_ff <= s3_degree_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_defect      = rsp_defect_ff;
   assign rsp_double_area = rsp_area_ff;
   assign rsp_degree      = rsp_degree_ff;

endmodule

`default_nettype wire

>>> design/pcc_checker.sv
// Port-level checker for the polygon cell checker, bound to the top level.
`default_nettype none

module pcc_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [pcc_pkg::DEFECT_BITS-1:0]   rsp_defect,
   input  pcc_pkg::area_type                 rsp_double_area,
   input  pcc_pkg::degree_type               rsp_degree
);
   import pcc_pkg::*;

   // No result is shown in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result keeps all of its fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_defect)
         && $stable(rsp_double_area) && $stable(rsp_degree))
      else $error("stalled result changed");

   // A degree outside the legal range always reports the degree defect.
   a_degree_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_degree < MIN_DEG_VALUE) || (rsp_degree > MAX_DEG_VALUE))
         |-> rsp_defect == DEFECT_DEGREE)
      else $error("bad degree without degree defect");

   // A clean cell has a strictly positive area.
   a_clean_area: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_defect == DEFECT_NONE)
         |-> !rsp_double_area[AREA_BITS-1] && (rsp_double_area != '0))
      else $error("clean cell with non-positive area");

   // The area defect is only raised for a non-positive area.
   a_area_defect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_defect == DEFECT_AREA)
         |-> rsp_double_area[AREA_BITS-1] || (rsp_double_area == '0))
      else $error("area defect on positive area");

endmodule

bind polygon_cell_checker pcc_checker u_pcc_checker (.*);

`default_nettype wire

>>> sim/pcc_area_checker.sv
// Watches the polygon cell checker's ports, predicts each cell result and compares it.
`default_nettype none

module pcc_area_checker (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   input  logic                              req_stall,
   input  pcc_pkg::id_type                   req_vertex_id,
   input  pcc_pkg::coord_type                req_coord_r,
   input  pcc_pkg::coord_type                req_coord_z,
   input  logic                              req_cell_end,

   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [pcc_pkg::DEFECT_BITS-1:0]   rsp_defect,
   input  pcc_pkg::area_type                 rsp_double_area,
   input  pcc_pkg::degree_type               rsp_degree,

   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [pcc_pkg::NODE_BITS-1:0]     csr_wdata,

   output int                                outstanding,
   output int                                failures
);

   timeunit 1ns;
   timeprecision 1ps;

   import pcc_pkg::*;

   localparam longint AREA_HI = (64'sd1 <<< (AREA_BITS - 1)) - 1;
   localparam longint AREA_LO = -AREA_HI - 1;

   typedef struct packed {
      logic [DEFECT_BITS-1:0] defect;
      area_type               double_area;
      degree_type             degree;
   } cell_verdict_type;

   logic [NODE_BITS-1:0] node_limit;
   id_type               id_row [MAX_DEGREE];
   int                   vertex_total;
   coord_type            first_r;
   coord_type            first_z;
   coord_type            prev_r;
   coord_type            prev_z;
   area_type             area_acc;
   logic                 out_of_range;
   logic                 dup_seen;
   logic                 neg_seen;
   cell_verdict_type     expected_cells [$];
   cell_verdict_type     want;
   int                   error_total = 0;

   function automatic area_type clamp_area(input longint sum);
      area_type result;
      if (sum > AREA_HI) begin
         result = area_type'(AREA_HI);
      end else if (sum < AREA_LO) begin
         result = area_type'(AREA_LO);
      end else begin
         result = area_type'(sum);
      end
      return result;
   endfunction

   // One shoelace term: a_r * b_z - b_r * a_z.
   function automatic longint edge_term(input coord_type ar, input coord_type az,
                                        input coord_type br, input coord_type bz);
      return longint'(ar) * longint'(bz) - longint'(br) * longint'(az);
   endfunction

   task automatic clear_cell();
      vertex_total = 0;
      first_r      = '0;
      first_z      = '0;
      prev_r       = '0;
      prev_z       = '0;
      area_acc     = '0;
      out_of_range = 1'b0;
      dup_seen     = 1'b0;
      neg_seen     = 1'b0;
   endtask

   task automatic take_vertex(input id_type id, input coord_type r, input coord_type z,
                              input logic last);
      int               stored;
      cell_verdict_type verdict;
      stored = (vertex_total < MAX_DEGREE) ? vertex_total : MAX_DEGREE;
      if ({1'b0, id} >= node_limit) begin
         out_of_range = 1'b1;
      end
      for (int i = 0; i < stored; i++) begin
         if (id_row[i] == id) begin
            dup_seen = 1'b1;
         end
      end
      if (r < 0) begin
         neg_seen = 1'b1;
      end
      if (vertex_total < MAX_DEGREE) begin
         id_row[vertex_total] = id;
      end
      if (vertex_total == 0) begin
         first_r = r;
         first_z = z;
      end else begin
         area_acc = clamp_area(longint'(area_acc) + edge_term(prev_r, prev_z, r, z));
      end
      prev_r = r;
      prev_z = z;
      if (vertex_total <= MAX_DEGREE) begin
         vertex_total++;
      end
      if (last) begin
         area_acc = clamp_area(longint'(area_acc) + edge_term(r, z, first_r, first_z));
         if (vertex_total < 3 || vertex_total > MAX_DEGREE) begin
            verdict.defect = DEFECT_DEGREE;
         end else if (out_of_range) begin
            verdict.defect = DEFECT_ID;
         end else if (dup_seen) begin
            verdict.defect = DEFECT_REPEAT;
         end else if (neg_seen) begin
            verdict.defect = DEFECT_RADIUS;
         end else if (area_acc <= 0) begin
            verdict.defect = DEFECT_AREA;
         end else begin
            verdict.defect = DEFECT_NONE;
         end
         verdict.double_area = area_acc;
         verdict.degree      = degree_type'(vertex_total);
         expected_cells.push_back(verdict);
         clear_cell();
      end
   endtask

   // Results are checked before the request of the same edge is folded in, since a
   // result always belongs to a cell that closed at an earlier edge.
   always @(posedge clock) begin
      if (reset) begin
         node_limit = NODE_COUNT_RESET;
         clear_cell();
         expected_cells.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               $error("result with no cell pending: defect %0d, double_area %0d, degree %0d",
                      rsp_defect, rsp_double_area, rsp_degree);
               error_total++;
            end else begin
               want = expected_cells.pop_front();
               if (rsp_defect !== want.defect) begin
                  $error("defect mismatch: expected %0d, actual %0d", want.defect, rsp_defect);
                  error_total++;
               end
               if (rsp_double_area !== want.double_area) begin
                  $error("double_area mismatch: expected %0d, actual %0d",
                         want.double_area, rsp_double_area);
                  error_total++;
               end
               if (rsp_degree !== want.degree) begin
                  $error("degree mismatch: expected %0d, actual %0d", want.degree, rsp_degree);
                  error_total++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            node_limit = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            take_vertex(req_vertex_id, req_coord_r, req_coord_z, req_cell_end);
         end
      end
      outstanding <= expected_cells.size();
      failures    <= error_total;
   end

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Top of the polygon cell checker testbench: clock, reset, vertex stimulus and verdict.
`default_nettype none

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import pcc_pkg::*;

   // Shapes of generated cells. A counterclockwise outline gives a positive area,
   // a clockwise one a negative area, noise is random in every field, and the loop
   // runs many times around the corners of the coordinate range so that the area
   // sum saturates.
   typedef enum {SHAPE_CCW, SHAPE_CW, SHAPE_NOISE, SHAPE_LOOP} outline_type;

   // Single defects planted into an otherwise well-formed cell.
   typedef enum {FLAW_NONE, FLAW_DUP, FLAW_NEG_R, FLAW_FAR_ID} flaw_type;

   localparam int ID_SPAN   = 1 << ID_BITS;
   localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
   localparam int MAX_CELL  = 48;
   localparam int ONE       = 4096;   // 1.0 in Q12.12

   logic                   clock;
   logic                   reset;

   logic                   req_valid;
   logic                   req_stall;
   id_type                 req_vertex_id;
   coord_type              req_coord_r;
   coord_type              req_coord_z;
   logic                   req_cell_end;

   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [DEFECT_BITS-1:0] rsp_defect;
   area_type               rsp_double_area;
   degree_type             rsp_degree;

   logic                   csr_valid;
   logic                   csr_ready;
   logic [NODE_BITS-1:0]   csr_wdata;

   int                     outstanding;
   int                     failures;

   int                     node_limit_now;
   int                     items_sent = 0;
   bit                     quiet_cell = 1'b0;

   polygon_cell_checker i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_vertex_id   (req_vertex_id),
      .req_coord_r     (req_coord_r),
      .req_coord_z     (req_coord_z),
      .req_cell_end    (req_cell_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_defect      (rsp_defect),
      .rsp_double_area (rsp_double_area),
      .rsp_degree      (rsp_degree),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   pcc_area_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_vertex_id   (req_vertex_id),
      .req_coord_r     (req_coord_r),
      .req_coord_z     (req_coord_z),
      .req_cell_end    (req_cell_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_defect      (rsp_defect),
      .rsp_double_area (rsp_double_area),
      .rsp_degree      (rsp_degree),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .outstanding     (outstanding),
      .failures        (failures)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs. The slowest correct run is far below this:
   // about 1150 requests, each with at most the longest gap and the longest stall.
   initial begin
      #4_000_000;
      $display("** polygon_cell_checker: FAILED **");
      $finish;
   end

   // Gap before a request. Most are zero or short, a few are long, and whole
   // cells marked quiet go through back to back.
   function automatic int pause_cycles();
      int p;
      p = $urandom_range(0, 99);
      if (quiet_cell || p < 65) begin
         return 0;
      end else if (p < 90) begin
         return $urandom_range(1, 3);
      end else if (p < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(15, 40);
   endfunction

   // The result side alternates between flowing and stalled stretches. Flowing
   // stretches are sometimes long so that the pipeline also runs without any
   // back-pressure.
   initial begin
      int run;
      bit stalling;
      int p;
      rsp_stall <= 1'b0;
      stalling = 1'b0;
      run = 0;
      forever begin
         @(posedge clock);
         if (run > 0) begin
            run--;
         end else begin
            stalling = !stalling;
            p = $urandom_range(0, 99);
            if (stalling) begin
               run = (p < 75) ? $urandom_range(1, 2) :
                     (p < 95) ? $urandom_range(3, 8) : $urandom_range(20, 40);
            end else begin
               run = (p < 70) ? $urandom_range(1, 6) :
                     (p < 90) ? $urandom_range(10, 40) : $urandom_range(60, 200);
            end
            rsp_stall <= stalling;
         end
      end
   end

   // Present one vertex and hold it until the block takes it. Valid stays high
   // after the request is taken, so a following vertex without a gap goes out in
   // the very next cycle.
   task automatic send_vertex(input id_type id, input coord_type r, input coord_type z,
                              input logic last);
      int gap;
      gap = pause_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_vertex_id <= id;
      req_coord_r   <= r;
      req_coord_z   <= z;
      req_cell_end  <= last;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // The node count may only change while no cell is open and no result is on its
   // way. Once every expected result is back, the bench also waits out the pipeline
   // before the write goes out.
   task automatic write_node_limit(input int value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wdata <= NODE_BITS'(value);
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      node_limit_now = value;
   endtask

   // Build one cell and send it. Counterclockwise outlines are x-monotone: a lower
   // chain with rising r, then an upper chain with falling r, the two chains kept
   // apart in z, so the area is positive. Ids step through the valid node range.
   task automatic send_cell(input int degree, input outline_type outline,
                            input flaw_type flaw);
      id_type    ids [MAX_CELL];
      coord_type rs [MAX_CELL];
      coord_type zs [MAX_CELL];
      coord_type swap;
      int        id_room;
      int        base;
      int        stride;
      int        span;
      int        pitch;
      int        base_r;
      int        z_low;
      int        lower_count;
      int        k;
      int        j;
      bit        backward;
      id_room     = (node_limit_now == 0) ? ID_SPAN : node_limit_now;
      base        = $urandom_range(0, id_room - 1);
      stride      = $urandom_range(1, 3);
      span        = 1 << $urandom_range(2, (degree <= 8) ? 19 : 16);
      pitch       = $urandom_range(1, span);
      base_r      = $urandom_range(0, span);
      z_low       = -$urandom_range(0, span);
      lower_count = (degree + 1) / 2;
      backward    = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < degree; i++) begin
         ids[i] = id_type'((longint'(base) + longint'(i) * stride) % id_room);
         if (i < lower_count) begin
            rs[i] = coord_type'(base_r + i * pitch);
            zs[i] = coord_type'(z_low + $urandom_range(0, pitch / 2));
         end else begin
            k = degree - 1 - i;
            rs[i] = coord_type'(base_r + k * pitch);
            zs[i] = coord_type'(z_low + span + 1 + $urandom_range(0, pitch / 2));
         end
      end
      case (outline)
         SHAPE_CW: begin
            for (int i = 0; i < degree / 2; i++) begin
               swap = rs[i];
               rs[i] = rs[degree - 1 - i];
               rs[degree - 1 - i] = swap;
               swap = zs[i];
               zs[i] = zs[degree - 1 - i];
               zs[degree - 1 - i] = swap;
            end
         end
         SHAPE_NOISE: begin
            for (int i = 0; i < degree; i++) begin
               ids[i] = id_type'($urandom);
               rs[i]  = coord_type'($urandom);
               zs[i]  = coord_type'($urandom);
            end
         end
         SHAPE_LOOP: begin
            // Corners in counterclockwise order; going backward gives the negative
            // extreme. Radius zero on the inner corners is legal.
            for (int i = 0; i < degree; i++) begin
               k = backward ? 3 - (i % 4) : i % 4;
               ids[i] = id_type'($urandom);
               rs[i]  = coord_type'((k < 2) ? COORD_MAX : 0);
               zs[i]  = coord_type'((k == 1 || k == 2) ? COORD_MAX : COORD_MIN);
            end
         end
         default: begin
         end
      endcase
      if (flaw != FLAW_NONE && degree >= 2) begin
         j = $urandom_range(1, degree - 1);
         case (flaw)
            FLAW_DUP: ids[j] = ids[$urandom_range(0, j - 1)];
            FLAW_NEG_R: rs[j] = coord_type'(-$urandom_range(1, span));
            FLAW_FAR_ID: begin
               ids[j] = (id_room < ID_SPAN) ? id_type'($urandom_range(id_room, ID_SPAN - 1))
                                            : id_type'($urandom);
            end
            default: begin
            end
         endcase
      end
      for (int i = 0; i < degree; i++) begin
         send_vertex(ids[i], rs[i], zs[i], i == degree - 1);
      end
   endtask

   // Mix of cells for the random part. Most are clean small polygons so that the
   // area and the later checks are reached; the rest cover planted defects,
   // clockwise outlines, too few and too many vertices, saturating loops and noise.
   task automatic random_cell();
      int          p;
      int          degree;
      outline_type outline;
      flaw_type    flaw;
      quiet_cell = ($urandom_range(0, 3) == 0);
      outline    = SHAPE_CCW;
      flaw       = FLAW_NONE;
      p          = $urandom_range(0, 99);
      if (p < 55) begin
         degree = $urandom_range(3, 8);
      end else if (p < 63) begin
         degree = $urandom_range(3, 10);
         flaw = flaw_type'($urandom_range(FLAW_DUP, FLAW_FAR_ID));
      end else if (p < 70) begin
         degree = $urandom_range(3, 8);
         outline = SHAPE_CW;
      end else if (p < 78) begin
         degree = $urandom_range(1, 2);
      end else if (p < 86) begin
         degree = $urandom_range(9, MAX_DEGREE);
      end else if (p < 90) begin
         degree = $urandom_range(MAX_DEGREE + 1, 24);
      end else if (p < 93) begin
         degree = $urandom_range(33, MAX_CELL);
         outline = SHAPE_LOOP;
      end else begin
         degree = $urandom_range(1, 10);
         outline = SHAPE_NOISE;
      end
      send_cell(degree, outline, flaw);
   endtask

   initial begin
      int limits [6];
      int quota [6];
      int target;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_vertex_id <= '0;
      req_coord_r   <= '0;
      req_coord_z   <= '0;
      req_cell_end  <= 1'b0;
      csr_valid     <= 1'b0;
      csr_wdata     <= '0;
      node_limit_now = int'(NODE_COUNT_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed cells under the reset node count.
      // A clean unit triangle with a vertex at radius zero.
      send_vertex(20'd0, 24'sd0, 24'sd0, 1'b0);
      send_vertex(20'd1, coord_type'(ONE), 24'sd0, 1'b0);
      send_vertex(20'd2, 24'sd0, coord_type'(ONE), 1'b1);
      // A cell of one vertex at the field extremes: the closing edge adds nothing.
      send_vertex(id_type'(ID_SPAN - 1), coord_type'(COORD_MAX), coord_type'(COORD_MIN), 1'b1);
      // Two vertices are too few.
      send_vertex(20'd3, coord_type'(ONE), 24'sd0, 1'b0);
      send_vertex(20'd4, 24'sd0, coord_type'(ONE), 1'b1);
      // A repeated node id.
      send_vertex(20'd7, 24'sd0, 24'sd0, 1'b0);
      send_vertex(20'd8, coord_type'(ONE), 24'sd0, 1'b0);
      send_vertex(20'd7, 24'sd0, coord_type'(ONE), 1'b1);
      // A negative radius.
      send_vertex(20'd9, coord_type'(-ONE), 24'sd0, 1'b0);
      send_vertex(20'd10, coord_type'(ONE), 24'sd0, 1'b0);
      send_vertex(20'd11, 24'sd0, coord_type'(ONE), 1'b1);
      // Clockwise order gives a negative area.
      send_vertex(20'd12, 24'sd0, 24'sd0, 1'b0);
      send_vertex(20'd13, 24'sd0, coord_type'(ONE), 1'b0);
      send_vertex(20'd14, coord_type'(ONE), 24'sd0, 1'b1);
      // Collinear vertices give zero area, which is also a defect.
      send_vertex(20'd15, 24'sd0, 24'sd0, 1'b0);
      send_vertex(20'd16, coord_type'(ONE), coord_type'(ONE), 1'b0);
      send_vertex(20'd17, coord_type'(2 * ONE), coord_type'(2 * ONE), 1'b1);
      // The largest triangle the coordinates allow, with the extreme node ids.
      send_vertex(20'd0, 24'sd0, coord_type'(COORD_MIN), 1'b0);
      send_vertex(id_type'(ID_SPAN - 1), coord_type'(COORD_MAX), coord_type'(COORD_MIN), 1'b0);
      send_vertex(id_type'(ID_SPAN / 2), 24'sd0, coord_type'(COORD_MAX), 1'b1);

      // Random phases, each under its own node count. A count of zero puts every id
      // out of range, one lets only node zero through, and the last phase returns
      // to the largest count.
      limits = '{0, 1, 0, ID_SPAN - 1, 0, ID_SPAN};
      limits[2] = $urandom_range(2, ID_SPAN - 1);
      limits[4] = $urandom_range(16, 4096);
      quota = '{60, 60, 240, 240, 240, 250};
      for (int phase = 0; phase < 6; phase++) begin
         write_node_limit(limits[phase]);
         target = items_sent + quota[phase];
         while (items_sent < target) begin
            random_cell();
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every expected result, then give the pipeline time to
      // show any result that should not be there.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("** polygon_cell_checker: PASSED **");
      end else begin
         $display("** polygon_cell_checker: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> polygon_cell_checker.f
design/pcc_pkg.sv
design/pcc_id_cell.sv
design/pcc_id_chain.sv
design/polygon_cell_checker.sv
design/pcc_checker.sv
sim/pcc_area_checker.sv
sim/testbench.sv
